// ===== rtl/ccbm_pkg.sv =====
package ccbm_pkg;

    localparam int COORD_FIELD_WIDTH = 32;
    localparam int CFG_INDEX_WIDTH   = 3;
    localparam int CFG_DATA_WIDTH    = 32;
    localparam int COUNT_WIDTH       = 3;

    localparam int DEF_MAX_CELL_VERTICES = 4;
    localparam int DEF_COORD_WIDTH       = 32;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_SHAPE_MODE = 3'd0,
        REG_INVERT     = 3'd1,
        REG_LOW_X      = 3'd2,
        REG_LOW_Y      = 3'd3,
        REG_LOW_Z      = 3'd4,
        REG_HIGH_X     = 3'd5,
        REG_HIGH_Y     = 3'd6,
        REG_HIGH_Z     = 3'd7
    } reg_index_t;

    typedef enum logic {
        SHAPE_BOX    = 1'b0,
        SHAPE_SPHERE = 1'b1
    } shape_t;

    typedef struct packed {
        shape_t shape_mode;
        logic   invert;
    } ctl_t;

    // one tested vertex leaving the region pipeline
    typedef struct packed {
        logic valid;
        logic last;
        logic in_region;
    } test_t;

endpackage

// ===== rtl/ccbm_vertex_if.sv =====
interface ccbm_vertex_if;
    logic                                        valid;
    logic                                        ready;
    logic signed [ccbm_pkg::COORD_FIELD_WIDTH-1:0] vertex_x;
    logic signed [ccbm_pkg::COORD_FIELD_WIDTH-1:0] vertex_y;
    logic signed [ccbm_pkg::COORD_FIELD_WIDTH-1:0] vertex_z;
    logic                                        last_vertex;

    modport source (output valid, vertex_x, vertex_y, vertex_z, last_vertex, input ready);
    modport sink   (input valid, vertex_x, vertex_y, vertex_z, last_vertex, output ready);
endinterface

// ===== rtl/ccbm_result_if.sv =====
interface ccbm_result_if;
    logic                              valid;
    logic                              ready;
    logic                              mask_value;
    logic [ccbm_pkg::COUNT_WIDTH-1:0]  inside_count;

    modport source (output valid, mask_value, inside_count, input ready);
    modport sink   (input valid, mask_value, inside_count, output ready);
endinterface

// ===== rtl/ccbm_cfg_if.sv =====
interface ccbm_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [ccbm_pkg::CFG_INDEX_WIDTH-1:0]  index;
    logic [ccbm_pkg::CFG_DATA_WIDTH-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/ccbm_cfg_regs.sv =====
module ccbm_cfg_regs #(
    parameter int COORD_WIDTH = ccbm_pkg::DEF_COORD_WIDTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 wr_en,
    input  logic [ccbm_pkg::CFG_INDEX_WIDTH-1:0] wr_index,
    input  logic [ccbm_pkg::CFG_DATA_WIDTH-1:0]  wr_data,
    output ccbm_pkg::ctl_t                       ctl,
    output logic signed [COORD_WIDTH-1:0]        low_x,
    output logic signed [COORD_WIDTH-1:0]        low_y,
    output logic signed [COORD_WIDTH-1:0]        low_z,
    output logic signed [COORD_WIDTH-1:0]        high_x,
    output logic signed [COORD_WIDTH-1:0]        high_y,
    output logic signed [COORD_WIDTH-1:0]        high_z
);

    ccbm_pkg::ctl_t               ctl_reg;
    logic signed [COORD_WIDTH-1:0] low_x_reg, low_y_reg, low_z_reg;
    logic signed [COORD_WIDTH-1:0] high_x_reg, high_y_reg, high_z_reg;
    logic signed [COORD_WIDTH-1:0] coord;

    assign coord = wr_data[COORD_WIDTH-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg    <= '{shape_mode: ccbm_pkg::SHAPE_BOX, invert: 1'b0};
            low_x_reg  <= '0;
            low_y_reg  <= '0;
            low_z_reg  <= '0;
            high_x_reg <= '0;
            high_y_reg <= '0;
            high_z_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (ccbm_pkg::reg_index_t'(wr_index))
                ccbm_pkg::REG_SHAPE_MODE: ctl_reg.shape_mode <= ccbm_pkg::shape_t'(wr_data[0]);
                ccbm_pkg::REG_INVERT:     ctl_reg.invert     <= wr_data[0];
                ccbm_pkg::REG_LOW_X:      low_x_reg          <= coord;
                ccbm_pkg::REG_LOW_Y:      low_y_reg          <= coord;
                ccbm_pkg::REG_LOW_Z:      low_z_reg          <= coord;
                ccbm_pkg::REG_HIGH_X:     high_x_reg         <= coord;
                ccbm_pkg::REG_HIGH_Y:     high_y_reg         <= coord;
                ccbm_pkg::REG_HIGH_Z:     high_z_reg         <= coord;
            endcase
        end
    end

    assign ctl    = ctl_reg;
    assign low_x  = low_x_reg;
    assign low_y  = low_y_reg;
    assign low_z  = low_z_reg;
    assign high_x = high_x_reg;
    assign high_y = high_y_reg;
    assign high_z = high_z_reg;

endmodule

// ===== rtl/ccbm_region_test.sv =====
module ccbm_region_test #(
    parameter int COORD_WIDTH = ccbm_pkg::DEF_COORD_WIDTH
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   advance,
    input  logic                                   in_valid,
    input  logic [ccbm_pkg::COORD_FIELD_WIDTH-1:0] in_x,
    input  logic [ccbm_pkg::COORD_FIELD_WIDTH-1:0] in_y,
    input  logic [ccbm_pkg::COORD_FIELD_WIDTH-1:0] in_z,
    input  logic                                   in_last,
    input  ccbm_pkg::ctl_t                         ctl,
    input  logic signed [COORD_WIDTH-1:0]          low_x,
    input  logic signed [COORD_WIDTH-1:0]          low_y,
    input  logic signed [COORD_WIDTH-1:0]          low_z,
    input  logic signed [COORD_WIDTH-1:0]          high_x,
    input  logic signed [COORD_WIDTH-1:0]          high_y,
    input  logic signed [COORD_WIDTH-1:0]          high_z,
    output ccbm_pkg::test_t                        test
);

    localparam int DIFF_WIDTH = COORD_WIDTH + 1;
    localparam int SQ_WIDTH   = 2 * COORD_WIDTH;
    localparam int SUM_WIDTH  = SQ_WIDTH + 2;
    localparam logic [DIFF_WIDTH-1:0] FAR_LIMIT = DIFF_WIDTH'(1) << (COORD_WIDTH - 1);

    // stage 1: captured vertex
    logic                          s1_valid_reg, s1_last_reg;
    logic signed [COORD_WIDTH-1:0] s1_x_reg, s1_y_reg, s1_z_reg;

    // stage 2: box result and distance magnitudes
    logic                          s2_valid_reg, s2_last_reg;
    logic                          s2_box_reg, s2_far_reg;
    logic [COORD_WIDTH-1:0]        s2_ax_reg, s2_ay_reg, s2_az_reg, s2_ar_reg;

    // stage 3: squares
    logic                          s3_valid_reg, s3_last_reg;
    logic                          s3_box_reg, s3_far_reg;
    logic [SQ_WIDTH-1:0]           s3_sx_reg, s3_sy_reg, s3_sz_reg, s3_sr_reg;

    logic signed [DIFF_WIDTH-1:0]  dx, dy, dz, rr;
    logic [DIFF_WIDTH-1:0]         mx, my, mz, mr;
    logic                          box_next, far_next;
    logic [SUM_WIDTH-1:0]          dist_sum;
    logic                          sphere_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_comb
    begin
        dx = DIFF_WIDTH'(s1_x_reg) - DIFF_WIDTH'(low_x);
        dy = DIFF_WIDTH'(s1_y_reg) - DIFF_WIDTH'(low_y);
        dz = DIFF_WIDTH'(s1_z_reg) - DIFF_WIDTH'(low_z);
        rr = DIFF_WIDTH'(high_x);
        mx = dx[DIFF_WIDTH-1] ? DIFF_WIDTH'(-dx) : DIFF_WIDTH'(dx);
        my = dy[DIFF_WIDTH-1] ? DIFF_WIDTH'(-dy) : DIFF_WIDTH'(dy);
        mz = dz[DIFF_WIDTH-1] ? DIFF_WIDTH'(-dz) : DIFF_WIDTH'(dz);
        mr = rr[DIFF_WIDTH-1] ? DIFF_WIDTH'(-rr) : DIFF_WIDTH'(rr);
        // beyond half range on any axis lies outside any radius
        far_next = (mx > FAR_LIMIT) || (my > FAR_LIMIT) || (mz > FAR_LIMIT);
        box_next = (low_x <= s1_x_reg) && (s1_x_reg <= high_x)
                && (low_y <= s1_y_reg) && (s1_y_reg <= high_y)
                && (low_z <= s1_z_reg) && (s1_z_reg <= high_z);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_last_reg <= in_last;
            s1_x_reg    <= in_x[COORD_WIDTH-1:0];
            s1_y_reg    <= in_y[COORD_WIDTH-1:0];
            s1_z_reg    <= in_z[COORD_WIDTH-1:0];

            s2_last_reg <= s1_last_reg;
            s2_box_reg  <= box_next;
            s2_far_reg  <= far_next;
            s2_ax_reg   <= mx[COORD_WIDTH-1:0];
            s2_ay_reg   <= my[COORD_WIDTH-1:0];
            s2_az_reg   <= mz[COORD_WIDTH-1:0];
            s2_ar_reg   <= mr[COORD_WIDTH-1:0];

            s3_last_reg <= s2_last_reg;
            s3_box_reg  <= s2_box_reg;
            s3_far_reg  <= s2_far_reg;
            s3_sx_reg   <= SQ_WIDTH'(s2_ax_reg) * SQ_WIDTH'(s2_ax_reg);
            s3_sy_reg   <= SQ_WIDTH'(s2_ay_reg) * SQ_WIDTH'(s2_ay_reg);
            s3_sz_reg   <= SQ_WIDTH'(s2_az_reg) * SQ_WIDTH'(s2_az_reg);
            s3_sr_reg   <= SQ_WIDTH'(s2_ar_reg) * SQ_WIDTH'(s2_ar_reg);
        end
    end

    always_comb
    begin
        dist_sum  = SUM_WIDTH'(s3_sx_reg) + SUM_WIDTH'(s3_sy_reg) + SUM_WIDTH'(s3_sz_reg);
        sphere_in = !s3_far_reg && (dist_sum <= SUM_WIDTH'(s3_sr_reg));
        test.valid     = s3_valid_reg;
        test.last      = s3_last_reg;
        test.in_region = (ctl.shape_mode == ccbm_pkg::SHAPE_SPHERE) ? sphere_in : s3_box_reg;
    end

endmodule

// ===== rtl/ccbm_cell_accum.sv =====
module ccbm_cell_accum #(
    parameter int MAX_CELL_VERTICES = ccbm_pkg::DEF_MAX_CELL_VERTICES
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ccbm_pkg::test_t                  test,
    input  logic                             invert,
    input  logic                             out_ready,
    output logic                             advance,
    output logic                             out_valid,
    output logic                             mask_value,
    output logic [ccbm_pkg::COUNT_WIDTH-1:0] inside_count
);

    localparam logic [ccbm_pkg::COUNT_WIDTH-1:0] COUNT_MAX =
        ccbm_pkg::COUNT_WIDTH'(MAX_CELL_VERTICES);

    logic                             all_inside_reg, all_inside_next;
    logic [ccbm_pkg::COUNT_WIDTH-1:0] hit_count_reg, hit_count_next;
    logic                             out_valid_reg, out_valid_next;
    logic                             mask_reg;
    logic [ccbm_pkg::COUNT_WIDTH-1:0] count_reg;
    logic                             cell_all;
    logic [ccbm_pkg::COUNT_WIDTH-1:0] cell_count;
    logic                             take;

    assign advance = !out_valid_reg || out_ready;
    assign take    = advance && test.valid;

    always_comb
    begin
        cell_all   = all_inside_reg && test.in_region;
        cell_count = (test.in_region && (hit_count_reg < COUNT_MAX))
                   ? hit_count_reg + 1'b1 : hit_count_reg;

        all_inside_next = all_inside_reg;
        hit_count_next  = hit_count_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        if (take)
        begin
            if (test.last)
            begin
                all_inside_next = 1'b1;
                hit_count_next  = '0;
                out_valid_next  = 1'b1;
            end
            else
            begin
                all_inside_next = cell_all;
                hit_count_next  = cell_count;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            all_inside_reg <= 1'b1;
            hit_count_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            all_inside_reg <= all_inside_next;
            hit_count_reg  <= hit_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && test.last)
        begin
            mask_reg  <= cell_all ^ invert;
            count_reg <= cell_count;
        end
    end

    assign out_valid    = out_valid_reg;
    assign mask_value   = mask_reg;
    assign inside_count = count_reg;

endmodule

// ===== rtl/cell_coordinate_bound_mask_top.sv =====
// Cell coordinate bound mask. Vertices stream in one item per cycle, each cell's
// vertices in order with last_vertex set on the final one; each vertex is tested
// against an inclusive axis-aligned box (shape_mode 0) or a sphere centred on
// low_x/y/z with radius high_x (shape_mode 1), and at a cell's last vertex one
// result item carries mask_value (all inside, XOR invert) and inside_count.
// Throughput is one vertex per cycle; a result passes from the input register that
// takes its last vertex through the compare/magnitude stage, the squaring stage and
// the result register. The whole pipeline holds only while a result waits at the
// output. Write configuration only while no cell is in flight.
module cell_coordinate_bound_mask_top #(
    parameter int MAX_CELL_VERTICES = ccbm_pkg::DEF_MAX_CELL_VERTICES,
    parameter int COORD_WIDTH       = ccbm_pkg::DEF_COORD_WIDTH
) (
    input logic            clk,
    input logic            rst_n,
    ccbm_vertex_if.sink    vertex,
    ccbm_result_if.source  result,
    ccbm_cfg_if.sink       cfg
);

    ccbm_pkg::ctl_t                ctl;
    ccbm_pkg::test_t               test;
    logic signed [COORD_WIDTH-1:0] low_x, low_y, low_z, high_x, high_y, high_z;
    logic                          advance;

    assign cfg.ready    = 1'b1;
    assign vertex.ready = advance;

    ccbm_cfg_regs #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .ctl      (ctl),
        .low_x    (low_x),
        .low_y    (low_y),
        .low_z    (low_z),
        .high_x   (high_x),
        .high_y   (high_y),
        .high_z   (high_z)
    );

    ccbm_region_test #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_region_test (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_valid (vertex.valid),
        .in_x     (vertex.vertex_x),
        .in_y     (vertex.vertex_y),
        .in_z     (vertex.vertex_z),
        .in_last  (vertex.last_vertex),
        .ctl      (ctl),
        .low_x    (low_x),
        .low_y    (low_y),
        .low_z    (low_z),
        .high_x   (high_x),
        .high_y   (high_y),
        .high_z   (high_z),
        .test     (test)
    );

    ccbm_cell_accum #(
        .MAX_CELL_VERTICES (MAX_CELL_VERTICES)
    ) u_cell_accum (
        .clk          (clk),
        .rst_n        (rst_n),
        .test         (test),
        .invert       (ctl.invert),
        .out_ready    (result.ready),
        .advance      (advance),
        .out_valid    (result.valid),
        .mask_value   (result.mask_value),
        .inside_count (result.inside_count)
    );

endmodule

// ===== verif/tb_cell_coordinate_bound_mask_top.sv =====
`timescale 1ns / 1ps

module tb_cell_coordinate_bound_mask_top;
    import ccbm_pkg::*;

    localparam int CELL_MAX       = DEF_MAX_CELL_VERTICES;
    localparam int PHASES         = 12;
    localparam int PHASE_VERTICES = 135;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES  = 8;
    localparam int MAX_PRINTED    = 100;

    typedef logic signed [COORD_FIELD_WIDTH-1:0] coord_t;

    localparam coord_t C_MIN = 32'sh8000_0000;
    localparam coord_t C_MAX = 32'sh7fff_ffff;

    typedef enum int {PICK_IN, PICK_EDGE, PICK_OUT, PICK_WILD} pick_t;

    typedef struct {
        coord_t x;
        coord_t y;
        coord_t z;
        logic   last;
    } vertex_item_t;

    typedef struct {
        logic                   mask_value;
        logic [COUNT_WIDTH-1:0] inside_count;
    } cell_mask_t;

    logic clk;
    logic rst_n;

    ccbm_vertex_if vertex_ch();
    ccbm_result_if result_ch();
    ccbm_cfg_if    cfg_ch();

    cell_coordinate_bound_mask_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .vertex (vertex_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    vertex_item_t vertex_pending[$];
    cell_mask_t   mask_expect[$];

    // shadow of the region registers
    shape_t region_shape  = SHAPE_BOX;
    logic   region_invert = 1'b0;
    coord_t region_lo[3]  = '{0, 0, 0};
    coord_t region_hi[3]  = '{0, 0, 0};

    // running state of the current cell
    logic                   cell_all_in = 1'b1;
    logic [COUNT_WIDTH-1:0] cell_hits   = '0;

    int src_idle_pct = 15;
    int snk_idle_pct = 54;
    int rx_hold_tag  = 0;
    int rx_hold_seen = 0;
    int rx_hold_left = 0;
    bit vertex_taken = 1'b0;
    int error_count  = 0;

    initial clk = 1'b0;

    always #4 clk = ~clk;

    task automatic flag_mismatch(input string msg);
        if (error_count < MAX_PRINTED)
            $display("MISMATCH at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic bit vertex_in_region(coord_t x, coord_t y, coord_t z);
        coord_t            v[3] = '{x, y, z};
        longint unsigned   mag[3];
        longint unsigned   rad;
        longint            d;
        bit                ok;
        ok = 1'b1;
        if (region_shape == SHAPE_BOX)
        begin
            for (int a = 0; a < 3; a++)
                if (v[a] < region_lo[a] || v[a] > region_hi[a])
                    ok = 1'b0;
            return ok;
        end
        for (int a = 0; a < 3; a++)
        begin
            d = longint'(v[a]) - longint'(region_lo[a]);
            mag[a] = (d < 0) ? -d : d;
            if (mag[a] > (64'd1 << 31))
                ok = 1'b0;
        end
        rad = (region_hi[0] < 0) ? -longint'(region_hi[0]) : longint'(region_hi[0]);
        return ok && (mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2] <= rad * rad);
    endfunction

    function automatic void predict_cell_mask(coord_t x, coord_t y, coord_t z, logic last);
        if (vertex_in_region(x, y, z))
        begin
            if (cell_hits < CELL_MAX)
                cell_hits++;
        end
        else
            cell_all_in = 1'b0;
        if (last)
        begin
            mask_expect.push_back('{mask_value: cell_all_in ^ region_invert,
                                    inside_count: cell_hits});
            cell_all_in = 1'b1;
            cell_hits   = '0;
        end
    endfunction

    function automatic longint pick_between(longint lo, longint hi);
        longint unsigned span = $unsigned(hi - lo) + 1;
        return lo + longint'({$urandom, $urandom} % span);
    endfunction

    function automatic vertex_item_t make_vertex(bit good, bit last);
        vertex_item_t v;
        coord_t       p[3];
        pick_t        pick;
        longint       r;
        longint       d;
        int           edge_axis;
        pick = ($urandom_range(4) == 0) ? PICK_EDGE : PICK_IN;
        edge_axis = $urandom_range(2);
        r = (region_hi[0] < 0) ? -longint'(region_hi[0]) : longint'(region_hi[0]);
        for (int a = 0; a < 3; a++)
        begin
            if (!good)
                pick = pick_t'($urandom_range(3));
            if (region_shape == SHAPE_BOX)
            begin
                case (pick)
                    PICK_IN:
                        p[a] = (region_lo[a] <= region_hi[a]) ?
                               coord_t'(pick_between(region_lo[a], region_hi[a])) : region_lo[a];
                    PICK_EDGE:
                        p[a] = $urandom_range(1) ? region_lo[a] : region_hi[a];
                    PICK_OUT:
                        p[a] = $urandom_range(1) ?
                               coord_t'(longint'(region_lo[a]) - pick_between(1, 64)) :
                               coord_t'(longint'(region_hi[a]) + pick_between(1, 64));
                    default:
                        p[a] = $urandom;
                endcase
            end
            else
            begin
                case (pick)
                    PICK_IN:   d = pick_between(-(r / 2), r / 2);
                    PICK_EDGE: d = (a == edge_axis) ? r : 0;
                    PICK_OUT:  d = r + pick_between(1, 64);
                    default:   d = longint'(coord_t'($urandom));
                endcase
                if ((pick == PICK_EDGE || pick == PICK_OUT) && $urandom_range(1))
                    d = -d;
                p[a] = coord_t'(longint'(region_lo[a]) + d);
            end
        end
        v.x    = p[0];
        v.y    = p[1];
        v.z    = p[2];
        v.last = last;
        return v;
    endfunction

    task automatic queue_vertex(coord_t x, coord_t y, coord_t z, logic last);
        vertex_pending.push_back('{x: x, y: y, z: z, last: last});
    endtask

    // mostly well-formed cells that sit in or on the region, the rest scattered
    task automatic queue_cell();
        int n;
        bit good;
        n = ($urandom_range(11) == 0) ? $urandom_range(CELL_MAX + 1, CELL_MAX + 3)
                                      : $urandom_range(1, CELL_MAX);
        good = ($urandom_range(99) < 60);
        for (int k = 0; k < n; k++)
            vertex_pending.push_back(make_vertex(good, k == n - 1));
    endtask

    task automatic write_reg(reg_index_t idx, logic [CFG_DATA_WIDTH-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            REG_SHAPE_MODE: region_shape  = shape_t'(value[0]);
            REG_INVERT:     region_invert = value[0];
            REG_LOW_X:      region_lo[0]  = value;
            REG_LOW_Y:      region_lo[1]  = value;
            REG_LOW_Z:      region_lo[2]  = value;
            REG_HIGH_X:     region_hi[0]  = value;
            REG_HIGH_Y:     region_hi[1]  = value;
            REG_HIGH_Z:     region_hi[2]  = value;
        endcase
    endtask

    task automatic program_region(shape_t shape, logic inv, coord_t lx, coord_t ly, coord_t lz,
                                  coord_t hx, coord_t hy, coord_t hz);
        write_reg(REG_SHAPE_MODE, {31'b0, shape});
        write_reg(REG_INVERT, {31'b0, inv});
        write_reg(REG_LOW_X, lx);
        write_reg(REG_LOW_Y, ly);
        write_reg(REG_LOW_Z, lz);
        write_reg(REG_HIGH_X, hx);
        write_reg(REG_HIGH_Y, hy);
        write_reg(REG_HIGH_Z, hz);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_region();
        coord_t lo[3];
        coord_t hi[3];
        coord_t c;
        coord_t w;
        shape_t shape;
        shape = shape_t'($urandom_range(1));
        for (int a = 0; a < 3; a++)
        begin
            c = coord_t'($urandom) >>> $urandom_range(31);
            w = $urandom >> $urandom_range(1, 31);
            case ($urandom_range(7))
                0:
                begin
                    lo[a] = C_MIN;
                    hi[a] = C_MAX;
                end
                1:
                begin
                    lo[a] = c;
                    hi[a] = c - 1 - $urandom_range(100);
                end
                2:
                begin
                    lo[a] = c;
                    hi[a] = c;
                end
                3:
                begin
                    lo[a] = $urandom;
                    hi[a] = $urandom;
                end
                default:
                begin
                    lo[a] = c - w;
                    hi[a] = c + w;
                end
            endcase
        end
        if (shape == SHAPE_SPHERE)
        begin
            w = $urandom >> $urandom_range(1, 31);
            case ($urandom_range(7))
                0:       hi[0] = 0;
                1:       hi[0] = C_MIN;
                2:       hi[0] = C_MAX;
                3:       hi[0] = -w;
                default: hi[0] = w;
            endcase
        end
        program_region(shape, $urandom_range(1), lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
    endtask

    // a trailing unflagged vertex may still be in the pipe after the last result
    task automatic wait_cells_done();
        while (vertex_pending.size() != 0 || vertex_ch.valid || mask_expect.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(negedge clk)
    begin
        vertex_item_t item;
        if (!rst_n)
            vertex_ch.valid <= 1'b0;
        else if (!vertex_ch.valid || vertex_taken)
        begin
            if (vertex_pending.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                item = vertex_pending.pop_front();
                vertex_ch.valid       <= 1'b1;
                vertex_ch.vertex_x    <= item.x;
                vertex_ch.vertex_y    <= item.y;
                vertex_ch.vertex_z    <= item.z;
                vertex_ch.last_vertex <= item.last;
            end
            else
                vertex_ch.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else if (rx_hold_seen != rx_hold_tag)
        begin
            rx_hold_seen    <= rx_hold_tag;
            rx_hold_left    <= RX_HOLD_CYCLES;
            result_ch.ready <= 1'b0;
        end
        else if (rx_hold_left != 0)
        begin
            rx_hold_left    <= rx_hold_left - 1;
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge clk)
    begin
        vertex_taken = rst_n && vertex_ch.valid && vertex_ch.ready;
        if (vertex_taken)
            predict_cell_mask(vertex_ch.vertex_x, vertex_ch.vertex_y, vertex_ch.vertex_z,
                              vertex_ch.last_vertex);
    end

    always @(posedge clk)
    begin
        cell_mask_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (mask_expect.size() == 0)
                flag_mismatch($sformatf("unexpected item: mask %0b count %0d",
                                        result_ch.mask_value, result_ch.inside_count));
            else
            begin
                want = mask_expect.pop_front();
                if (result_ch.mask_value !== want.mask_value)
                    flag_mismatch($sformatf("mask_value %0b, expected %0b",
                                            result_ch.mask_value, want.mask_value));
                if (result_ch.inside_count !== want.inside_count)
                    flag_mismatch($sformatf("inside_count %0d, expected %0d",
                                            result_ch.inside_count, want.inside_count));
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("cell_coordinate_bound_mask_top test failed");
        $finish;
    end

    initial
    begin
        rst_n                 = 1'b0;
        vertex_ch.valid       = 1'b0;
        vertex_ch.vertex_x    = '0;
        vertex_ch.vertex_y    = '0;
        vertex_ch.vertex_z    = '0;
        vertex_ch.last_vertex = 1'b0;
        result_ch.ready       = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = REG_SHAPE_MODE;
        cfg_ch.data           = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset region is the single point at the origin
        queue_vertex(0, 0, 0, 1'b1);
        queue_vertex(1, 0, 0, 1'b1);
        wait_cells_done();

        // inclusive bounds, one vertex out, overlong cell
        program_region(SHAPE_BOX, 1'b0, -100, -200, -300, 100, 200, 300);
        queue_vertex(-100, -200, -300, 1'b1);
        queue_vertex(100, 200, 300, 1'b1);
        queue_vertex(-101, 0, 0, 1'b0);
        queue_vertex(0, 0, 0, 1'b1);
        queue_vertex(0, 0, 0, 1'b0);
        queue_vertex(1, 2, 3, 1'b0);
        queue_vertex(-1, -2, -3, 1'b0);
        queue_vertex(0, 0, 301, 1'b1);
        for (int k = 0; k < 5; k++)
            queue_vertex(k, -k, k, k == 4);
        wait_cells_done();

        program_region(SHAPE_BOX, 1'b1, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
        queue_vertex(C_MIN, C_MIN, C_MIN, 1'b0);
        queue_vertex(C_MAX, C_MAX, C_MAX, 1'b1);
        wait_cells_done();

        // empty box on x
        program_region(SHAPE_BOX, 1'b0, 10, C_MIN, C_MIN, 9, C_MAX, C_MAX);
        queue_vertex(10, 0, 0, 1'b1);
        wait_cells_done();

        // negative radius, on and just past the surface
        program_region(SHAPE_SPHERE, 1'b0, 10, 20, 30, -5, C_MAX, C_MIN);
        queue_vertex(13, 24, 30, 1'b1);
        queue_vertex(13, 24, 31, 1'b1);
        wait_cells_done();

        // largest radius, offsets at and beyond 2^31
        program_region(SHAPE_SPHERE, 1'b1, C_MAX, C_MAX, C_MAX, C_MIN, 0, 0);
        queue_vertex(-1, C_MAX, C_MAX, 1'b1);
        queue_vertex(C_MIN, C_MIN, C_MIN, 1'b1);
        wait_cells_done();

        for (int p = 0; p < PHASES; p++)
        begin
            src_idle_pct = (p < 4) ? 15 : (p < 8) ? 54 : 0;
            snk_idle_pct = (p < 4) ? 54 : (p < 8) ? 15 : 0;
            random_region();
            if (p == 8)
                rx_hold_tag++;
            while (vertex_pending.size() < PHASE_VERTICES)
                queue_cell();
            wait_cells_done();
        end

        if (error_count == 0)
            $display("cell_coordinate_bound_mask_top test passed");
        else
            $display("cell_coordinate_bound_mask_top test failed");
        $finish;
    end

endmodule
